/* hdl/smt_pkg.sv */
// ----------------------------------------------------------------------------
// smt_pkg: shared definitions for the sorted multiset table
// Operation and status codes, field widths and the controller/datapath links.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package smt_pkg;

  // Field widths
  localparam int unsigned OP_W  = 2;
  localparam int unsigned VAL_W = 32;
  localparam int unsigned ST_W  = 2;
  localparam int unsigned OUT_W = 7;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT     = 2'd0;
  localparam logic [OP_W-1:0] OP_REMOVE_ONE = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE_ALL = 2'd2;
  localparam logic [OP_W-1:0] OP_REMOVE_TOP = 2'd3;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_EMPTY     = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd3;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // capture the request and set up the scan
    logic read_top;  // read the largest stored entry
    logic grab_top;  // take the largest entry as the removal target
    logic run;       // issue scan reads
    logic finish;    // commit the count and present the result
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic empty;       // no stored entries
    logic full;        // table at capacity
    logic rem_zero;    // no scan reads left to issue
    logic pipe_valid;  // read data still in flight
  } sts_t;

endpackage

/* hdl/smt_datapath.sv */
// ----------------------------------------------------------------------------
// smt_datapath: entry memory, scan counters and result registers
// Streams the stored entries through one read and one write port, shifting
// them up for an insert or compacting them down for a removal.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smt_datapath #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  smt_pkg::cmd_t                     cmd_i,
  output smt_pkg::sts_t                     sts_o,
  input  logic [smt_pkg::OP_W-1:0]          op_i,
  input  logic signed [smt_pkg::VAL_W-1:0]  value_i,
  output logic                              done_o,
  output logic [smt_pkg::ST_W-1:0]          status_o,
  output logic [smt_pkg::OUT_W-1:0]         size_o,
  output logic [smt_pkg::OUT_W-1:0]         removed_count_o
);
  import smt_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  // Entry memory
  logic [VAL_W-1:0] mem [CAPACITY];
  logic [AW-1:0]    raddr;
  logic [AW-1:0]    waddr;
  logic [VAL_W-1:0] wdata;
  logic             we;
  logic signed [VAL_W-1:0] rdata_q;

  // Request and scan state
  logic [OP_W-1:0]         op_q;
  logic signed [VAL_W-1:0] target_q;
  logic                    skip_q;
  logic                    ins_done_q, ins_done_d;
  logic [CW-1:0]           count_q;
  logic [CW-1:0]           rem_q;
  logic [CW-1:0]           removed_q, removed_d;
  logic [AW-1:0]           rd_idx_q;
  logic [AW-1:0]           rp_q;
  logic                    rv_q;
  logic                    issue;
  logic                    is_insert;
  logic                    match;

  // Result registers
  logic                    done_q;
  logic [ST_W-1:0]         status_q;
  logic [OUT_W-1:0]        size_q;
  logic [OUT_W-1:0]        removed_out_q;
  logic [CW-1:0]           count_next;
  logic [ST_W-1:0]         status_next;

  assign is_insert = (op_q == OP_INSERT);
  assign issue     = cmd_i.run && (rem_q != '0);
  assign raddr     = cmd_i.read_top ? AW'(count_q - CW'(1)) : rd_idx_q;

  assign sts_o.empty      = (count_q == '0);
  assign sts_o.full       = (count_q >= CW'(CAPACITY));
  assign sts_o.rem_zero   = (rem_q == '0);
  assign sts_o.pipe_valid = rv_q;

  // Remove this entry if it equals the target; a single removal stops at one
  assign match = (rdata_q == target_q) &&
                 !((op_q == OP_REMOVE_ONE) && (removed_q != '0));

  // Process returned data and pick the write
  always_comb begin
    we         = 1'b0;
    waddr      = rp_q;
    wdata      = rdata_q;
    ins_done_d = ins_done_q;
    removed_d  = removed_q;
    if (rv_q) begin
      if (is_insert) begin
        if (!ins_done_q) begin
          we    = 1'b1;
          waddr = rp_q + AW'(1);
          if (rdata_q < target_q) begin
            wdata      = target_q;
            ins_done_d = 1'b1;
          end
        end
      end else if (match) begin
        removed_d = removed_q + CW'(1);
      end else begin
        we    = 1'b1;
        waddr = rp_q - AW'(removed_q);
      end
    end else if (cmd_i.finish && is_insert && !skip_q && !ins_done_q) begin
      // value is below every stored entry
      we    = 1'b1;
      waddr = '0;
      wdata = target_q;
    end
    // Clear the scan flags for a new request
    if (cmd_i.load) begin
      ins_done_d = 1'b0;
      removed_d  = '0;
    end
  end

  // Memory ports, read data registered
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_q <= mem[raddr];
  end

  // Count and status after the operation
  always_comb begin
    count_next  = count_q;
    status_next = ST_OK;
    if (skip_q) begin
      status_next = is_insert ? ST_FULL : ST_EMPTY;
    end else if (is_insert) begin
      count_next = count_q + CW'(1);
    end else begin
      count_next = count_q - removed_q;
      if ((op_q == OP_REMOVE_ONE) && (removed_q == '0)) begin
        status_next = ST_NOT_FOUND;
      end
    end
  end

  // Control state: count, scan counters, pipeline valid, result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      rem_q      <= '0;
      rv_q       <= 1'b0;
      done_q     <= 1'b0;
      ins_done_q <= 1'b0;
      removed_q  <= '0;
      skip_q     <= 1'b0;
      op_q       <= OP_INSERT;
    end else begin
      rv_q       <= issue;
      done_q     <= cmd_i.finish;
      ins_done_q <= ins_done_d;
      removed_q  <= removed_d;
      if (cmd_i.load) begin
        op_q <= op_i;
        if (op_i == OP_INSERT) begin
          skip_q <= sts_o.full;
          rem_q  <= sts_o.full ? '0 : count_q;
        end else begin
          skip_q <= sts_o.empty;
          rem_q  <= count_q;
        end
      end else if (issue) begin
        rem_q <= rem_q - CW'(1);
      end
      if (cmd_i.finish) begin
        count_q <= count_next;
      end
    end
  end

  // Scan indices and target
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      target_q <= value_i;
      rd_idx_q <= (op_i == OP_INSERT) ? AW'(count_q - CW'(1)) : '0;
    end else if (issue) begin
      rd_idx_q <= is_insert ? rd_idx_q - AW'(1) : rd_idx_q + AW'(1);
    end
    if (cmd_i.grab_top) begin
      target_q <= rdata_q;
    end
    if (issue) begin
      rp_q <= rd_idx_q;
    end
    if (cmd_i.finish) begin
      status_q      <= status_next;
      size_q        <= OUT_W'(count_next);
      removed_out_q <= OUT_W'(removed_q);
    end
  end

  assign done_o          = done_q;
  assign status_o        = status_q;
  assign size_o          = size_q;
  assign removed_count_o = removed_out_q;

endmodule

/* hdl/smt_controller.sv */
// ----------------------------------------------------------------------------
// smt_controller: sequencer for the sorted multiset table
// Steps each request through the optional top read, the scan and the commit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module smt_controller (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     start_i,
  input  logic [smt_pkg::OP_W-1:0] op_i,
  input  smt_pkg::sts_t            sts_i,
  output smt_pkg::cmd_t            cmd_o,
  output logic                     busy_o
);
  import smt_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TOP_RD  = 3'd1;
  localparam logic [2:0] S_TOP_CAP = 3'd2;
  localparam logic [2:0] S_RUN     = 3'd3;
  localparam logic [2:0] S_FIN     = 3'd4;

  logic [2:0] state_q, state_d;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cmd_o.load = 1'b1;
          if ((op_i == OP_REMOVE_TOP) && !sts_i.empty) begin
            state_d = S_TOP_RD;
          end else begin
            state_d = S_RUN;
          end
        end
      end
      S_TOP_RD: begin
        cmd_o.read_top = 1'b1;
        state_d        = S_TOP_CAP;
      end
      S_TOP_CAP: begin
        cmd_o.grab_top = 1'b1;
        state_d        = S_RUN;
      end
      S_RUN: begin
        cmd_o.run = 1'b1;
        if (sts_i.rem_zero && !sts_i.pipe_valid) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        cmd_o.finish = 1'b1;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy_o = (state_q != S_IDLE);

endmodule

/* hdl/sorted_multiset_table.sv */
// ----------------------------------------------------------------------------
// sorted_multiset_table: ascending table of signed values, duplicates allowed
// Each request scans the stored entries through the single read port, after a read of the largest
// entry for remove-largest; nothing is scanned for an empty table or a full-table insert.
// Throughput: one request at a time; start is taken again the cycle done_o shows.
// Reset clears the entry count and control state; the entry memory is not cleared.
// Results are strobed for one cycle by done_o; the receiver cannot stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sorted_multiset_table #(
  parameter int unsigned CAPACITY = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  output logic                              busy_o,
  input  logic [smt_pkg::OP_W-1:0]          op_i,
  input  logic signed [smt_pkg::VAL_W-1:0]  value_i,
  output logic                              done_o,
  output logic [smt_pkg::ST_W-1:0]          status_o,
  output logic [smt_pkg::OUT_W-1:0]         size_o,
  output logic [smt_pkg::OUT_W-1:0]         removed_count_o
);
  import smt_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  smt_controller u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .op_i   (op_i),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy_o (busy_o)
  );

  // Storage and scan
  smt_datapath #(
    .CAPACITY(CAPACITY)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .op_i           (op_i),
    .value_i        (value_i),
    .done_o         (done_o),
    .status_o       (status_o),
    .size_o         (size_o),
    .removed_count_o(removed_count_o)
  );

endmodule
